// ===== rtl/core/abbsc_pkg.sv =====
`default_nettype none

package abbsc_pkg;

   // Command codes carried in the op field of a request.
   typedef enum logic [1:0] {
      OP_LOAD           = 2'd0,
      OP_QUERY          = 2'd1,
      OP_MARK_SUCCESS   = 2'd2,
      OP_ACTIVATE_OTHER = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SLOT   = 2'd1,
      STATUS_BAD_MAGIC = 2'd2
   } status_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PRIORITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRIES    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_MODE   = 2'd2;
   localparam int unsigned CSR_DATA_W = 8;

   // Reset values of the configuration registers.
   localparam logic [7:0] MAX_PRIORITY_RESET = 8'd15;
   localparam logic [7:0] MAX_TRIES_RESET    = 8'd7;
   localparam logic       RETRY_MODE_RESET   = 1'b0;

   typedef struct packed {
      op_type     op;
      logic       slot_index;
      logic [7:0] load_priority;
      logic [7:0] load_tries;
      logic       load_successful;
      logic [7:0] load_last_boot;
      logic       load_magic_ok;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       current_slot;
      logic [7:0] slot_a_priority;
      logic [7:0] slot_a_tries;
      logic       slot_a_successful;
      logic [7:0] slot_b_priority;
      logic [7:0] slot_b_tries;
      logic       slot_b_successful;
      logic [7:0] last_boot_out;
   } rsp_type;

   // Stored boot records; index 0 is slot A, index 1 is slot B.
   typedef struct packed {
      logic [1:0][7:0] priority_val;
      logic [1:0][7:0] tries;
      logic [1:0]      success;
      logic [7:0]      prev_boot;
      logic            magic_good;
   } state_type;

   typedef struct packed {
      logic [7:0] max_priority;
      logic [7:0] max_tries;
      logic       retry_mode;
   } cfg_type;

   // Outcome of the slot selection on the state before a request.
   typedef struct packed {
      logic found;
      logic slot;
   } sel_type;

endpackage

`default_nettype wire

// ===== rtl/core/ab_boot_slot_controller_top.sv =====
`default_nettype none

// A/B boot slot controller. A request is taken at every clock edge where start is
// high; busy is never raised, so one request can follow another in each cycle. Its
// result passes through the request register and then the result register, and
// appears on rsp_data marked by rsp_valid, which is high for exactly one cycle; the
// receiver cannot stall it. Slot selection and record update are done in one
// combinational pass between the two registers; the records themselves are written at
// the same edge as the result, so each request sees the effect of the one before it.
// Configuration registers are written through csr_we, csr_index and csr_wdata and
// should only be changed while no request is in flight.
module ab_boot_slot_controller_top (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        start,
   output logic                                       busy,
   input  abbsc_pkg::req_type                         req_data,
   output logic                                       rsp_valid,
   output abbsc_pkg::rsp_type                         rsp_data,
   input  wire                                        csr_we,
   input  wire [abbsc_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  wire [abbsc_pkg::CSR_DATA_W-1:0]            csr_wdata
);

   logic                 req_valid_ff;
   abbsc_pkg::req_type   req_ff;
   abbsc_pkg::state_type state_ff;
   abbsc_pkg::state_type state_in;
   abbsc_pkg::cfg_type   cfg_ff;
   abbsc_pkg::cfg_type   cfg_in;
   logic                 rsp_valid_ff;
   abbsc_pkg::rsp_type   rsp_ff;
   abbsc_pkg::rsp_type   rsp_in;
   abbsc_pkg::sel_type   sel;

   assign busy = 1'b0;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            abbsc_pkg::CSR_MAX_PRIORITY: cfg_in.max_priority = csr_wdata[7:0];
            abbsc_pkg::CSR_MAX_TRIES:    cfg_in.max_tries    = csr_wdata[7:0];
            abbsc_pkg::CSR_RETRY_MODE:   cfg_in.retry_mode   = csr_wdata[0];
            default:                     cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_priority <= abbsc_pkg::MAX_PRIORITY_RESET;
         cfg_ff.max_tries    <= abbsc_pkg::MAX_TRIES_RESET;
         cfg_ff.retry_mode   <= abbsc_pkg::RETRY_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         req_ff <= req_data;
      end
   end

   abbsc_slot_select u_select (
      .state (state_ff),
      .sel   (sel)
   );

   abbsc_update u_update (
      .req        (req_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .sel        (sel),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // Boot records change only when a registered request is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_valid_ff) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/abbsc_slot_select.sv =====
`default_nettype none

module abbsc_slot_select (
   input  abbsc_pkg::state_type state,
   output abbsc_pkg::sel_type   sel
);

   logic [1:0] bootable;

   // A slot can boot when it has priority and is either confirmed or has tries left.
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         bootable[s] = (state.priority_val[s] != 8'd0) &&
                       (state.success[s] || (state.tries[s] != 8'd0));
      end
   end

   // Higher priority wins, a tie goes to slot A, and the last-boot value is the fallback.
   always_comb begin
      sel.found = 1'b1;
      sel.slot  = 1'b0;
      priority if (bootable[0] && bootable[1]) begin
         sel.slot = (state.priority_val[1] > state.priority_val[0]);
      end else if (bootable[0]) begin
         sel.slot = 1'b0;
      end else if (bootable[1]) begin
         sel.slot = 1'b1;
      end else if (state.prev_boot == 8'd0) begin
         sel.slot = 1'b0;
      end else if (state.prev_boot == 8'd1) begin
         sel.slot = 1'b1;
      end else begin
         sel.found = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/abbsc_update.sv =====
`default_nettype none

module abbsc_update (
   input  abbsc_pkg::req_type   req,
   input  abbsc_pkg::state_type state,
   input  abbsc_pkg::cfg_type   cfg,
   input  abbsc_pkg::sel_type   sel,
   output abbsc_pkg::state_type state_next,
   output abbsc_pkg::rsp_type   rsp
);

   abbsc_pkg::status_type status;
   logic [7:0]            lowered_priority;
   logic                  other;

   // The slot giving up top priority drops one step below it, stopping at zero.
   assign lowered_priority = (cfg.max_priority == 8'd0) ? 8'd0 : cfg.max_priority - 8'd1;
   assign other            = ~sel.slot;

   // Apply the command to the stored records.
   always_comb begin
      state_next = state;
      status     = abbsc_pkg::STATUS_OK;
      unique case (req.op)
         abbsc_pkg::OP_LOAD: begin
            state_next.priority_val[req.slot_index] = req.load_priority;
            state_next.tries[req.slot_index]        = req.load_tries;
            state_next.success[req.slot_index]      = req.load_successful;
            state_next.prev_boot                    = req.load_last_boot;
            state_next.magic_good                   = req.load_magic_ok;
         end
         abbsc_pkg::OP_QUERY: begin
            if (!sel.found) begin
               status = abbsc_pkg::STATUS_NO_SLOT;
            end
         end
         abbsc_pkg::OP_MARK_SUCCESS: begin
            if (!sel.found) begin
               status = abbsc_pkg::STATUS_NO_SLOT;
            end else if (!state.magic_good) begin
               status = abbsc_pkg::STATUS_BAD_MAGIC;
            end else begin
               state_next.priority_val[sel.slot] = cfg.max_priority;
               state_next.tries[sel.slot]   = cfg.retry_mode ? cfg.max_tries : 8'd0;
               state_next.success[sel.slot] = ~cfg.retry_mode;
               state_next.prev_boot         = {7'd0, sel.slot};
            end
         end
         abbsc_pkg::OP_ACTIVATE_OTHER: begin
            if (!sel.found) begin
               status = abbsc_pkg::STATUS_NO_SLOT;
            end else begin
               state_next.priority_val[sel.slot] = lowered_priority;
               state_next.priority_val[other]    = cfg.max_priority;
               state_next.tries[other]           = cfg.max_tries;
               state_next.success[other]         = 1'b0;
            end
         end
         default: begin
            status = abbsc_pkg::STATUS_OK;
         end
      endcase
   end

   // The result reports the selection before the update and the records after it.
   always_comb begin
      rsp.status            = status;
      rsp.current_slot      = sel.found ? sel.slot : 1'b0;
      rsp.slot_a_priority   = state_next.priority_val[0];
      rsp.slot_a_tries      = state_next.tries[0];
      rsp.slot_a_successful = state_next.success[0];
      rsp.slot_b_priority   = state_next.priority_val[1];
      rsp.slot_b_tries      = state_next.tries[1];
      rsp.slot_b_successful = state_next.success[1];
      rsp.last_boot_out     = state_next.prev_boot;
   end

endmodule

`default_nettype wire
